/* rtl/ed_pkg.sv */
`default_nettype none

package ed_pkg;

   localparam int DEFAULT_MAX_DIMS    = 64;
   localparam int DEFAULT_COORD_WIDTH = 24;

   // fixed field widths of the channels
   localparam int COORD_PORT_W = 24;
   localparam int DIST_W       = 28;

   // unsigned Q54.0 (integer) accumulator and its square root
   localparam int SUM_W  = 54;
   localparam int ROOT_W = SUM_W / 2;
   localparam int REM_W  = ROOT_W + 3;
   localparam int STEP_W = $clog2(ROOT_W);

   localparam logic [SUM_W-1:0] SUM_MAX = '1;

   // result queue between accumulator and root unit
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic             saturated;
   } ed_entry_type;

   typedef struct packed {
      logic         valid;
      ed_entry_type entry;
   } ed_push_type;

   typedef enum logic [1:0] {
      ROOT_IDLE,
      ROOT_RUN,
      ROOT_DONE
   } root_state_type;

endpackage

`default_nettype wire

/* rtl/euclidean_distance.sv */
// channel   direction  payload                                   handshake
// req_      in         coord_a[23:0], coord_b[23:0], last_pair   req_valid / req_ready
// rsp_      out        distance[27:0], saturated                 rsp_valid / rsp_ready
//
// Pairs enter at one per cycle while req_ready is high, through a three-stage pipe
// (difference, square, accumulate). A closing pair drops its sum into a four-entry
// queue. The square root unit resolves one result bit per cycle: it loads a sum,
// iterates, hands the root to the output once that is free, then loads another.
// req_ready drops while the queue and the closing pairs in flight fill it.
// Synchronous reset clears the sum, count, flag, queue and output valid.
`default_nettype none

module euclidean_distance import ed_pkg::*; #(
   parameter int MAX_DIMS    = DEFAULT_MAX_DIMS,
   parameter int COORD_WIDTH = DEFAULT_COORD_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [COORD_PORT_W-1:0] req_coord_a,
   input  logic [COORD_PORT_W-1:0] req_coord_b,
   input  logic                    req_last_pair,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [DIST_W-1:0]       rsp_distance,
   output logic                    rsp_saturated
);

   ed_push_type        push;
   ed_entry_type       head;
   logic               not_empty;
   logic               pop;
   logic [LEVEL_W-1:0] level;

   ed_front #(
      .MAX_DIMS    (MAX_DIMS),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_coord_a   (req_coord_a),
      .req_coord_b   (req_coord_b),
      .req_last_pair (req_last_pair),
      .queue_level   (level),
      .push          (push)
   );

   ed_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .level     (level)
   );

   ed_root u_root (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .not_empty     (not_empty),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_distance  (rsp_distance),
      .rsp_saturated (rsp_saturated)
   );

endmodule

`default_nettype wire

/* rtl/ed_front.sv */
`default_nettype none

module ed_front import ed_pkg::*; #(
   parameter int MAX_DIMS    = DEFAULT_MAX_DIMS,
   parameter int COORD_WIDTH = DEFAULT_COORD_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [COORD_PORT_W-1:0] req_coord_a,
   input  logic [COORD_PORT_W-1:0] req_coord_b,
   input  logic                    req_last_pair,
   input  logic [LEVEL_W-1:0]      queue_level,
   output ed_push_type             push
);

   localparam int DIFF_W = COORD_WIDTH + 1;
   localparam int SQ_W   = 2 * DIFF_W;
   localparam int CNT_W  = $clog2(MAX_DIMS + 1);

   logic              accept;
   logic [DIFF_W-1:0] a_ext;
   logic [DIFF_W-1:0] b_ext;
   logic [DIFF_W-1:0] diff;
   logic [DIFF_W-1:0] mag;
   logic [LEVEL_W:0]  occupancy;

   logic              s1_valid_ff, s1_valid_in;
   logic              s1_last_ff;
   logic [DIFF_W-1:0] s1_mag_ff;

   logic              s2_valid_ff, s2_valid_in;
   logic              s2_last_ff;
   logic [SQ_W-1:0]   s2_sq_ff;

   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ovf_ff, ovf_in;

   logic [SUM_W-1:0]  sum_next;
   logic [CNT_W-1:0]  count_next;
   logic              ovf_next;
   logic [SUM_W:0]    total;
   logic              at_limit;

   // only the low COORD_WIDTH bits count, sign-extended
   assign a_ext = DIFF_W'($signed(req_coord_a[COORD_WIDTH-1:0]));
   assign b_ext = DIFF_W'($signed(req_coord_b[COORD_WIDTH-1:0]));
   assign diff  = a_ext - b_ext;
   assign mag   = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;

   // reserve a queue slot for every closing pair still in the pipe
   assign occupancy = (LEVEL_W+1)'(queue_level)
                    + (LEVEL_W+1)'(s1_valid_ff & s1_last_ff)
                    + (LEVEL_W+1)'(s2_valid_ff & s2_last_ff);
   assign req_ready = occupancy < (LEVEL_W+1)'(QUEUE_DEPTH);
   assign accept    = req_valid && req_ready;

   assign s1_valid_in = accept;
   assign s2_valid_in = s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_mag_ff  <= mag;
      s1_last_ff <= req_last_pair;
      s2_sq_ff   <= s1_mag_ff * s1_mag_ff;
      s2_last_ff <= s1_last_ff;
   end

   assign total    = {1'b0, sum_ff} + {1'b0, SUM_W'(s2_sq_ff)};
   assign at_limit = count_ff >= CNT_W'(MAX_DIMS);

   always_comb begin
      sum_next   = sum_ff;
      count_next = count_ff;
      ovf_next   = ovf_ff;
      if (at_limit) begin
         sum_next = SUM_MAX;
         ovf_next = 1'b1;
      end else begin
         count_next = count_ff + 1'b1;
         if (ovf_ff || total[SUM_W]) begin
            sum_next = SUM_MAX;
            ovf_next = 1'b1;
         end else begin
            sum_next = total[SUM_W-1:0];
         end
      end
   end

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (s2_valid_ff) begin
         if (s2_last_ff) begin
            sum_in   = '0;
            count_in = '0;
            ovf_in   = 1'b0;
         end else begin
            sum_in   = sum_next;
            count_in = count_next;
            ovf_in   = ovf_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign push.valid           = s2_valid_ff & s2_last_ff;
   assign push.entry.sum       = sum_next;
   assign push.entry.saturated = ovf_next;

endmodule

`default_nettype wire

/* rtl/ed_queue.sv */
`default_nettype none

module ed_queue import ed_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  ed_push_type        push,
   input  logic               pop,
   output ed_entry_type       head,
   output logic               not_empty,
   output logic [LEVEL_W-1:0] level
);

   ed_entry_type         entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [LEVEL_W-1:0]   level_ff, level_in;
   logic                 do_pop;

   assign do_pop = pop && (level_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push.valid) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push.valid && !do_pop) begin
         level_in = level_ff + 1'b1;
      end else if (!push.valid && do_pop) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entries_ff[wr_ptr_ff] <= push.entry;
      end
   end

   assign head      = entries_ff[rd_ptr_ff];
   assign not_empty = level_ff != '0;
   assign level     = level_ff;

endmodule

`default_nettype wire

/* rtl/ed_root.sv */
`default_nettype none

module ed_root import ed_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  ed_entry_type      head,
   input  logic              not_empty,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [DIST_W-1:0] rsp_distance,
   output logic              rsp_saturated
);

   root_state_type      state_ff, state_in;

   logic [SUM_W-1:0]    rad_ff, rad_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                sat_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0]   rsp_distance_ff;
   logic                rsp_saturated_ff;

   logic                load;
   logic                iterate;
   logic                store;
   logic                last_step;
   logic                out_free;

   logic [REM_W-1:0]    rem_shift;
   logic [REM_W-1:0]    trial;
   logic                fits;

   assign last_step = step_ff == STEP_W'(ROOT_W - 1);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ROOT_IDLE: if (not_empty) state_in = ROOT_RUN;
         ROOT_RUN:  if (last_step) state_in = ROOT_DONE;
         ROOT_DONE: if (out_free)  state_in = ROOT_IDLE;
         default:   state_in = ROOT_IDLE;
      endcase
   end

   always_comb begin
      load    = 1'b0;
      iterate = 1'b0;
      store   = 1'b0;
      unique case (state_ff)
         ROOT_IDLE: load    = not_empty;
         ROOT_RUN:  iterate = 1'b1;
         ROOT_DONE: store   = out_free;
         default: begin
            load    = 1'b0;
            iterate = 1'b0;
            store   = 1'b0;
         end
      endcase
   end

   assign pop = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ROOT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // one result bit per cycle: bring down two radicand bits, try root*4+1
   assign rem_shift = {rem_ff[REM_W-3:0], rad_ff[SUM_W-1 -: 2]};
   assign trial     = REM_W'({root_ff, 2'b01});
   assign fits      = rem_shift >= trial;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      step_in = step_ff;
      if (load) begin
         rad_in  = head.sum;
         rem_in  = '0;
         root_in = '0;
         step_in = '0;
      end else if (iterate) begin
         rad_in  = {rad_ff[SUM_W-3:0], 2'b00};
         rem_in  = fits ? (rem_shift - trial) : rem_shift;
         root_in = {root_ff[ROOT_W-2:0], fits};
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      step_ff <= step_in;
      if (load) begin
         sat_ff <= head.saturated;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (store) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store) begin
         rsp_distance_ff  <= DIST_W'(root_ff);
         rsp_saturated_ff <= sat_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_distance  = rsp_distance_ff;
   assign rsp_saturated = rsp_saturated_ff;

endmodule

`default_nettype wire

/* rtl/ed_checker.sv */
`default_nettype none

module ed_checker import ed_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic [COORD_PORT_W-1:0] req_coord_a,
   input logic [COORD_PORT_W-1:0] req_coord_b,
   input logic                    req_last_pair,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [DIST_W-1:0]       rsp_distance,
   input logic                    rsp_saturated
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance)
         && $stable(rsp_saturated))
      else $error("result changed while stalled");

   // reset drops the output valid
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // the root of a 54-bit sum fits in 27 bits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_distance[DIST_W-1])
      else $error("distance out of range");

   // a saturated sum is all ones, so its root is all ones too
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_distance == DIST_W'(SUM_MAX[ROOT_W-1:0]))
      else $error("saturated result with wrong distance");

   // a stalled request holds its payload
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_coord_a)
         && $stable(req_coord_b) && $stable(req_last_pair))
      else $error("request changed while stalled");

endmodule

bind euclidean_distance ed_checker u_checker (.*);

`default_nettype wire

/* tb/tb_euclidean_distance.sv */
`default_nettype none

module tb_euclidean_distance;
   import ed_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD  = 4;
   localparam int MAX_PAIRS    = DEFAULT_MAX_DIMS;
   localparam int CW           = DEFAULT_COORD_WIDTH;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 64;
   localparam int ITEM_TARGET  = 500;
   localparam int RUN_LIMIT_NS = 2000000;

   localparam logic [COORD_PORT_W-1:0] C_MAX = 24'h7FFFFF;
   localparam logic [COORD_PORT_W-1:0] C_MIN = 24'h800000;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              saturated;
   } dist_result_type;

   typedef struct packed {
      bit              typed;
      dist_result_type value;
   } pair_note_type;

   typedef struct packed {
      logic [COORD_PORT_W-1:0] a;
      logic [COORD_PORT_W-1:0] b;
      logic                    last;
      bit                      typed;
      logic [DIST_W-1:0]       distance;
      logic                    saturated;
   } pair_row_type;

   // typed expectations only where the root is a whole number at a glance
   localparam pair_row_type DIRECTED[18] = '{
      '{24'h000000, 24'h000000, 1'b1, 1'b1, 28'd0,        1'b0},
      '{C_MAX,      C_MIN,      1'b1, 1'b1, 28'd16777215, 1'b0},
      '{C_MIN,      C_MAX,      1'b1, 1'b1, 28'd16777215, 1'b0},
      '{C_MAX,      C_MAX,      1'b1, 1'b1, 28'd0,        1'b0},
      '{C_MIN,      C_MIN,      1'b1, 1'b1, 28'd0,        1'b0},
      '{24'h000001, 24'h000000, 1'b1, 1'b1, 28'd1,        1'b0},
      '{24'hFFFFFF, 24'h000001, 1'b1, 1'b1, 28'd2,        1'b0},
      '{24'h000003, 24'h000000, 1'b0, 1'b0, 28'd0,        1'b0},
      '{24'h000000, 24'h000004, 1'b1, 1'b1, 28'd5,        1'b0},
      '{24'h010000, 24'h000000, 1'b0, 1'b0, 28'd0,        1'b0},
      '{24'h000000, 24'h010000, 1'b0, 1'b0, 28'd0,        1'b0},
      '{24'h010000, 24'h010000, 1'b1, 1'b0, 28'd0,        1'b0},
      '{24'h123456, 24'hFEDCBA, 1'b0, 1'b0, 28'd0,        1'b0},
      '{24'h0ABCDE, 24'h654321, 1'b1, 1'b0, 28'd0,        1'b0},
      '{C_MAX,      C_MIN,      1'b0, 1'b0, 28'd0,        1'b0},
      '{C_MIN,      C_MAX,      1'b0, 1'b0, 28'd0,        1'b0},
      '{C_MAX,      C_MIN,      1'b0, 1'b0, 28'd0,        1'b0},
      '{C_MIN,      C_MAX,      1'b1, 1'b1, 28'd33554430, 1'b0}
   };

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [COORD_PORT_W-1:0] req_coord_a = '0;
   logic [COORD_PORT_W-1:0] req_coord_b = '0;
   logic                    req_last_pair = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [DIST_W-1:0]       rsp_distance;
   logic                    rsp_saturated;

   // predictor state
   logic [SUM_W-1:0] acc_sum;
   int               acc_pairs;
   bit               acc_sat;

   dist_result_type dist_q[$];
   pair_note_type   note_q[$];

   int fail_count    = 0;
   int sent_count    = 0;
   int rsp_stall_left = 0;
   int rsp_hold_left  = 0;
   int rsp_max_stall  = 14;

   euclidean_distance dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_coord_a   (req_coord_a),
      .req_coord_b   (req_coord_b),
      .req_last_pair (req_last_pair),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_distance  (rsp_distance),
      .rsp_saturated (rsp_saturated)
   );

   always #(HALF_PERIOD) clock = ~clock;

   function automatic logic [DIST_W-1:0] floor_root(input logic [SUM_W-1:0] x);
      logic [63:0] r;
      logic [63:0] cand;
      int          i;
      r = '0;
      for (i = ROOT_W - 1; i >= 0; i--) begin
         cand = r | (64'd1 << i);
         if (cand * cand <= 64'(x)) r = cand;
      end
      return r[DIST_W-1:0];
   endfunction

   task automatic accumulate_pair(input logic [COORD_PORT_W-1:0] a_raw,
                                  input logic [COORD_PORT_W-1:0] b_raw,
                                  input logic last,
                                  output dist_result_type res);
      longint      a_val;
      longint      b_val;
      longint      diff;
      logic [63:0] sq;
      a_val = longint'(signed'(a_raw[CW-1:0]));
      b_val = longint'(signed'(b_raw[CW-1:0]));
      diff = a_val - b_val;
      if (diff < 0) diff = -diff;
      sq = 64'(diff) * 64'(diff);
      if (acc_pairs >= MAX_PAIRS) begin
         acc_pairs = MAX_PAIRS;
         acc_sum   = SUM_MAX;
         acc_sat   = 1'b1;
      end else begin
         acc_pairs++;
         if (acc_sat || sq > 64'(SUM_MAX) - 64'(acc_sum)) begin
            acc_sum = SUM_MAX;
            acc_sat = 1'b1;
         end else begin
            acc_sum = acc_sum + sq[SUM_W-1:0];
         end
      end
      res = '0;
      if (last) begin
         res.distance  = floor_root(acc_sum);
         res.saturated = acc_sat;
         acc_sum   = '0;
         acc_pairs = 0;
         acc_sat   = 1'b0;
      end
   endtask

   function automatic logic [COORD_PORT_W-1:0] rand_coord();
      case ($urandom_range(0, 3))
         0: begin
            case ($urandom_range(0, 3))
               0: return C_MAX;
               1: return C_MIN;
               2: return '0;
               default: return '1;
            endcase
         end
         1: return COORD_PORT_W'($urandom_range(0, 255)) - COORD_PORT_W'(128);
         default: return COORD_PORT_W'($urandom);
      endcase
   endfunction

   // Drive one pair at a falling edge and hold it until accepted.
   task automatic send_pair(input logic [COORD_PORT_W-1:0] a,
                            input logic [COORD_PORT_W-1:0] b,
                            input logic last,
                            input bit typed,
                            input dist_result_type typed_value,
                            input int gap_cap);
      int            gap;
      pair_note_type note;
      gap = $urandom_range(0, gap_cap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_coord_a   <= a;
      req_coord_b   <= b;
      req_last_pair <= last;
      req_valid     <= 1'b1;
      note.typed = typed;
      note.value = typed_value;
      note_q.insert(note_q.size(), note);
      sent_count++;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
   endtask

   task automatic send_vector(input int len, input int gap_cap, input bit wide);
      logic [COORD_PORT_W-1:0] a;
      logic [COORD_PORT_W-1:0] b;
      int                      k;
      for (k = 0; k < len; k++) begin
         if (wide) begin
            a = $urandom_range(0, 1) ? C_MAX : C_MIN;
            b = (a == C_MAX) ? C_MIN : C_MAX;
         end else begin
            a = rand_coord();
            b = rand_coord();
         end
         send_pair(a, b, k == len - 1, 1'b0, '0, gap_cap);
      end
   endtask

   task automatic wait_drained();
      while (dist_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // receiver: long hold takes priority over the per-transaction stall
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_ready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // check results first, then predict from the accepted request
   always @(posedge clock) begin
      dist_result_type want;
      dist_result_type pred;
      pair_note_type   note;
      if (reset) begin
         acc_sum   = '0;
         acc_pairs = 0;
         acc_sat   = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (dist_q.size() == 0) begin
               $display("%0t: unexpected result distance %0d saturated %0d",
                        $time, rsp_distance, rsp_saturated);
               fail_count++;
            end else begin
               want = dist_q.pop_front();
               if (rsp_distance !== want.distance || rsp_saturated !== want.saturated) begin
                  $display("%0t: mismatch: expected distance %0d saturated %0d, got %0d %0d",
                           $time, want.distance, want.saturated,
                           rsp_distance, rsp_saturated);
                  fail_count++;
               end
            end
            rsp_stall_left = $urandom_range(0, rsp_max_stall);
         end
         if (req_valid && req_ready) begin
            note = note_q.pop_front();
            accumulate_pair(req_coord_a, req_coord_b, req_last_pair, pred);
            if (req_last_pair) dist_q.insert(dist_q.size(), note.typed ? note.value : pred);
         end
      end
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("tb_euclidean_distance failed");
      $finish;
   end

   initial begin
      int           i;
      int           len;
      int           gap_cap;
      pair_row_type row;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (i = 0; i < $size(DIRECTED); i++) begin
         row = DIRECTED[i];
         send_pair(row.a, row.b, row.last, row.typed, '{row.distance, row.saturated},
                   $urandom_range(0, 3));
      end

      // full-length vector, then one pair past the limit, then a longer one
      send_vector(MAX_PAIRS, 2, 1'b1);
      send_vector(MAX_PAIRS + 1, 0, 1'b1);
      send_vector(MAX_PAIRS + 2, 14, 1'b0);

      // back up the queue behind a long receiver hold
      @(posedge clock);
      rsp_hold_left = LONG_HOLD;
      @(negedge clock);
      for (i = 0; i < 40; i++) send_vector($urandom_range(1, 2), 0, 1'b0);
      req_valid <= 1'b0;
      wait_drained();

      while (sent_count < ITEM_TARGET) begin
         gap_cap       = ($urandom_range(0, 3) == 0) ? 0 : 14;
         rsp_max_stall = ($urandom_range(0, 3) == 0) ? 0 : 14;
         len = ($urandom_range(0, 19) == 0) ? $urandom_range(MAX_PAIRS - 4, MAX_PAIRS + 3)
                                           : $urandom_range(1, 8);
         send_vector(len, gap_cap, $urandom_range(0, 7) == 0);
      end
      req_valid <= 1'b0;
      wait_drained();

      if (fail_count == 0) begin
         $display("tb_euclidean_distance passed");
      end else begin
         $display("tb_euclidean_distance failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
